[hw/rtl/dtcffr_pkg.sv]
// Shared types and constants of the trouble code recorder with freeze frame.
package dtcffr_pkg;

  // Fixed field widths
  localparam int unsigned MASK_W       = 3;
  localparam int unsigned SEL_W        = 2;
  localparam int unsigned TRIG_W       = 2;
  localparam int unsigned STATUS_W     = 2;
  localparam int unsigned STATUS_VEC_W = 6;
  localparam int unsigned COUNT_VEC_W  = 24;

  // Action codes carried by an input word
  typedef enum logic [1:0] {
    ACT_CHECK        = 2'd0,
    ACT_CLEAR_ALL    = 2'd1,
    ACT_CLEAR_SENSOR = 2'd2
  } action_e;

  // Per-sensor trouble code status
  typedef enum logic [STATUS_W-1:0] {
    ST_NONE    = 2'd0,
    ST_ACTIVE  = 2'd1,
    ST_HISTORY = 2'd2
  } status_e;

  // Input word
  typedef struct packed {
    logic [1:0]        action;
    logic [MASK_W-1:0] critical_mask;
    logic [7:0]        speed;
    logic [13:0]       rpm;
    logic signed [7:0] temperature;
    logic [SEL_W-1:0]  sensor_select;
  } in_item_t;

  // Result word
  typedef struct packed {
    logic [STATUS_VEC_W-1:0] status_vector;
    logic [COUNT_VEC_W-1:0]  count_vector;
    logic                    frozen_valid;
    logic [TRIG_W-1:0]       frozen_trigger;
    logic [7:0]              frozen_speed;
    logic [13:0]             frozen_rpm;
    logic signed [7:0]       frozen_temperature;
  } out_item_t;

  // Freeze frame record
  typedef struct packed {
    logic              valid;
    logic [TRIG_W-1:0] trigger;
    logic [7:0]        speed;
    logic [13:0]       rpm;
    logic signed [7:0] temperature;
  } snap_t;

endpackage

[hw/rtl/dtcffr_if.sv]
// Valid/ready channel interfaces for the input and result words.
interface dtcffr_in_if;
  logic                 valid;
  logic                 ready;
  dtcffr_pkg::in_item_t payload;

  modport source (output valid, output payload, input ready);
  modport sink (input valid, input payload, output ready);
endinterface

interface dtcffr_out_if;
  logic                  valid;
  logic                  ready;
  dtcffr_pkg::out_item_t payload;

  modport source (output valid, output payload, input ready);
  modport sink (input valid, input payload, output ready);
endinterface

[hw/rtl/dtcffr_update.sv]
// Next-state logic of the recorder for one input word.
module dtcffr_update #(
  parameter int unsigned NUM_SENSORS = 3,
  parameter int unsigned COUNT_BITS  = 8
) (
  input  dtcffr_pkg::in_item_t            item_i,
  input  logic [dtcffr_pkg::MASK_W-1:0]   prev_i,
  input  dtcffr_pkg::status_e             status_i [NUM_SENSORS],
  input  logic [COUNT_BITS-1:0]           count_i  [NUM_SENSORS],
  input  dtcffr_pkg::snap_t               snap_i,
  output logic [dtcffr_pkg::MASK_W-1:0]   prev_o,
  output dtcffr_pkg::status_e             status_o [NUM_SENSORS],
  output logic [COUNT_BITS-1:0]           count_o  [NUM_SENSORS],
  output dtcffr_pkg::snap_t               snap_o
);

  // Sensors that can see a critical flag at all
  localparam int unsigned LIVE = (NUM_SENSORS < dtcffr_pkg::MASK_W) ?
                                 NUM_SENSORS : dtcffr_pkg::MASK_W;

  logic [NUM_SENSORS-1:0]        cur_vec;
  logic [NUM_SENSORS-1:0]        was_vec;
  logic [NUM_SENSORS-1:0]        rise_vec;
  logic [dtcffr_pkg::TRIG_W-1:0] first_rise;
  logic                          sel_ok;

  // Extract current and previous flags, find rising edges
  always_comb begin
    cur_vec = '0;
    was_vec = '0;
    for (int i = 0; i < LIVE; i++) begin
      cur_vec[i] = item_i.critical_mask[i];
      was_vec[i] = prev_i[i];
    end
    rise_vec = cur_vec & ~was_vec;
  end

  // Pick the lowest rising sensor as trigger
  always_comb begin
    first_rise = '0;
    for (int i = NUM_SENSORS - 1; i >= 0; i--) begin
      if (rise_vec[i]) begin
        first_rise = dtcffr_pkg::TRIG_W'(i);
      end
    end
  end

  assign sel_ok = int'(item_i.sensor_select) < NUM_SENSORS;

  // Apply the action
  always_comb begin
    prev_o   = prev_i;
    status_o = status_i;
    count_o  = count_i;
    snap_o   = snap_i;
    unique case (dtcffr_pkg::action_e'(item_i.action))
      dtcffr_pkg::ACT_CHECK: begin
        for (int i = 0; i < NUM_SENSORS; i++) begin
          if (cur_vec[i]) begin
            // count a new edge, saturating
            if (rise_vec[i] && (count_i[i] != {COUNT_BITS{1'b1}})) begin
              count_o[i] = count_i[i] + COUNT_BITS'(1);
            end
            status_o[i] = dtcffr_pkg::ST_ACTIVE;
          end else if (status_i[i] == dtcffr_pkg::ST_ACTIVE) begin
            status_o[i] = dtcffr_pkg::ST_HISTORY;
          end
        end
        // capture the freeze frame on the first edge
        if (!snap_i.valid && (|rise_vec)) begin
          snap_o.valid       = 1'b1;
          snap_o.trigger     = first_rise;
          snap_o.speed       = item_i.speed;
          snap_o.rpm         = item_i.rpm;
          snap_o.temperature = item_i.temperature;
        end
        prev_o = item_i.critical_mask;
      end
      dtcffr_pkg::ACT_CLEAR_ALL: begin
        prev_o = '0;
        for (int i = 0; i < NUM_SENSORS; i++) begin
          status_o[i] = dtcffr_pkg::ST_NONE;
          count_o[i]  = '0;
        end
        snap_o = '0;
      end
      dtcffr_pkg::ACT_CLEAR_SENSOR: begin
        for (int i = 0; i < NUM_SENSORS; i++) begin
          if (int'(item_i.sensor_select) == i) begin
            status_o[i] = dtcffr_pkg::ST_NONE;
            count_o[i]  = '0;
          end
        end
        // drop the frame if this sensor captured it
        if (sel_ok && snap_i.valid && (snap_i.trigger == item_i.sensor_select)) begin
          snap_o = '0;
        end
      end
      default: begin
        // unused action code: hold everything
      end
    endcase
  end

endmodule

[hw/rtl/dtc_freeze_frame_recorder_unit.sv]
// Top level of the trouble code recorder with a single freeze frame.
//
//   channel | dir | word             | accepted when
//   --------+-----+------------------+----------------------
//   in_i    | in  | action + snapshot| in_i.valid & in_i.ready
//   out_o   | out | status + frame   | out_o.valid & out_o.ready
//
// One word per cycle while out_o.ready keeps the result register free; each word
// passes through the input register, then the result register, and the result
// is set by the single update pass between them.
// Reset clears all records, the previous critical flags and both stage valids.
// The input stage takes a new word while the result register drains; with the
// result stalled, one more word waits in the input register and ready drops.
module dtc_freeze_frame_recorder_unit #(
  parameter int unsigned NUM_SENSORS = 3,
  parameter int unsigned COUNT_BITS  = 8
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  dtcffr_in_if.sink           in_i,
  dtcffr_out_if.source        out_o
);

  localparam int unsigned SV_FULL_W = dtcffr_pkg::STATUS_W * NUM_SENSORS;
  localparam int unsigned SV_PAD_W  = (SV_FULL_W > dtcffr_pkg::STATUS_VEC_W) ?
                                      SV_FULL_W : dtcffr_pkg::STATUS_VEC_W;
  localparam int unsigned CV_FULL_W = COUNT_BITS * NUM_SENSORS;
  localparam int unsigned CV_PAD_W  = (CV_FULL_W > dtcffr_pkg::COUNT_VEC_W) ?
                                      CV_FULL_W : dtcffr_pkg::COUNT_VEC_W;

  logic                          in_valid_q;
  logic                          in_valid_d;
  dtcffr_pkg::in_item_t          in_item_q;
  logic                          out_valid_q;
  logic                          out_valid_d;
  dtcffr_pkg::out_item_t         out_item_q;
  dtcffr_pkg::out_item_t         out_item_d;
  logic                          out_free;
  logic                          advance;
  logic                          in_take;

  logic [dtcffr_pkg::MASK_W-1:0] prev_q;
  logic [dtcffr_pkg::MASK_W-1:0] prev_d;
  dtcffr_pkg::status_e           status_q [NUM_SENSORS];
  dtcffr_pkg::status_e           status_d [NUM_SENSORS];
  logic [COUNT_BITS-1:0]         count_q  [NUM_SENSORS];
  logic [COUNT_BITS-1:0]         count_d  [NUM_SENSORS];
  dtcffr_pkg::snap_t             snap_q;
  dtcffr_pkg::snap_t             snap_d;

  logic [SV_PAD_W-1:0]           sv_pad;
  logic [CV_PAD_W-1:0]           cv_pad;

  // Handshake: the input word moves on whenever the result register can take it
  assign out_free    = !out_valid_q || out_o.ready;
  assign advance     = in_valid_q && out_free;
  assign in_i.ready  = !in_valid_q || out_free;
  assign in_take     = in_i.valid && in_i.ready;
  assign in_valid_d  = in_take ? 1'b1 : (out_free ? 1'b0 : in_valid_q);
  assign out_valid_d = advance ? 1'b1 : (out_o.ready ? 1'b0 : out_valid_q);

  // Compute the record update for the word in the input register
  dtcffr_update #(
    .NUM_SENSORS (NUM_SENSORS),
    .COUNT_BITS  (COUNT_BITS)
  ) u_update (
    .item_i   (in_item_q),
    .prev_i   (prev_q),
    .status_i (status_q),
    .count_i  (count_q),
    .snap_i   (snap_q),
    .prev_o   (prev_d),
    .status_o (status_d),
    .count_o  (count_d),
    .snap_o   (snap_d)
  );

  // Pack the updated records into the result word, dropping overflow bits
  always_comb begin
    sv_pad = '0;
    cv_pad = '0;
    for (int i = 0; i < NUM_SENSORS; i++) begin
      sv_pad[dtcffr_pkg::STATUS_W*i +: dtcffr_pkg::STATUS_W] = status_d[i];
      cv_pad[COUNT_BITS*i +: COUNT_BITS]                     = count_d[i];
    end
    out_item_d.status_vector      = sv_pad[dtcffr_pkg::STATUS_VEC_W-1:0];
    out_item_d.count_vector       = cv_pad[dtcffr_pkg::COUNT_VEC_W-1:0];
    out_item_d.frozen_valid       = snap_d.valid;
    out_item_d.frozen_trigger     = snap_d.trigger;
    out_item_d.frozen_speed       = snap_d.speed;
    out_item_d.frozen_rpm         = snap_d.rpm;
    out_item_d.frozen_temperature = snap_d.temperature;
  end

  // Hold stage valids
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      in_valid_q  <= in_valid_d;
      out_valid_q <= out_valid_d;
    end
  end

  // Capture the input word
  always_ff @(posedge clk_i) begin
    if (in_take) begin
      in_item_q <= in_i.payload;
    end
  end

  // Load the result word
  always_ff @(posedge clk_i) begin
    if (advance) begin
      out_item_q <= out_item_d;
    end
  end

  // Advance the records once per word
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      prev_q <= '0;
      snap_q <= '0;
      for (int i = 0; i < NUM_SENSORS; i++) begin
        status_q[i] <= dtcffr_pkg::ST_NONE;
        count_q[i]  <= '0;
      end
    end else if (advance) begin
      prev_q <= prev_d;
      snap_q <= snap_d;
      for (int i = 0; i < NUM_SENSORS; i++) begin
        status_q[i] <= status_d[i];
        count_q[i]  <= count_d[i];
      end
    end
  end

  assign out_o.valid   = out_valid_q;
  assign out_o.payload = out_item_q;

`ifndef NO_ASSERTIONS
  // An empty freeze frame reads as all zero
  a_empty_frame_zero : assert property (@(posedge clk_i) disable iff (!rst_ni)
    !snap_q.valid |-> (snap_q == '0))
    else $error("freeze frame not zero while empty");

  // The trigger always names an existing sensor
  a_trigger_in_range : assert property (@(posedge clk_i) disable iff (!rst_ni)
    snap_q.valid |-> (int'(snap_q.trigger) < NUM_SENSORS))
    else $error("freeze frame trigger out of range");

  // A clear-all word yields an all-zero result
  a_clear_all_zero : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (advance && (in_item_q.action == dtcffr_pkg::ACT_CLEAR_ALL))
    |=> (out_valid_q && (out_item_q == '0)))
    else $error("clear-all result not zero");

  // Records change only when a word moves into the result register
  a_records_hold : assert property (@(posedge clk_i) disable iff (!rst_ni)
    !advance |=> ($stable(snap_q) && $stable(prev_q)))
    else $error("records changed without a word");
`endif

endmodule

[tb/tb_top.sv]
// Self-checking testbench for the trouble code recorder with freeze frame.
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned NUM_SENSORS = 3;
  localparam int unsigned COUNT_BITS  = 8;
  localparam logic [COUNT_BITS-1:0] COUNT_MAX = '1;
  // Action code with no meaning; the block only reports its state
  localparam logic [1:0] ACT_UNUSED = 2'd3;
  // Sensor index past the last sensor
  localparam logic [dtcffr_pkg::SEL_W-1:0] SEL_OUT_OF_RANGE =
    dtcffr_pkg::SEL_W'(NUM_SENSORS);
  localparam int unsigned RANDOM_WORDS = 400;
  localparam int unsigned SAT_PAIRS = 260;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;

  dtcffr_in_if  in_if ();
  dtcffr_out_if out_if ();

  dtc_freeze_frame_recorder_unit #(
    .NUM_SENSORS(NUM_SENSORS),
    .COUNT_BITS (COUNT_BITS)
  ) dut (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .in_i  (in_if),
    .out_o (out_if)
  );

  always #2 clk_i = ~clk_i;

  // Recorder shadow state
  logic [dtcffr_pkg::MASK_W-1:0] last_critical;
  dtcffr_pkg::status_e           code_st [NUM_SENSORS];
  logic [COUNT_BITS-1:0]         occurrences [NUM_SENSORS];
  dtcffr_pkg::snap_t             frame;

  dtcffr_pkg::out_item_t expected_reports[$];
  int unsigned errors = 0;
  int unsigned words_sent = 0;
  int unsigned reports_seen = 0;
  bit steady = 1'b0;

  function automatic void clear_records();
    last_critical = '0;
    for (int i = 0; i < NUM_SENSORS; i++) begin
      code_st[i]     = dtcffr_pkg::ST_NONE;
      occurrences[i] = '0;
    end
    frame = '0;
  endfunction

  // Apply one action to the shadow state and return the report it yields
  function automatic dtcffr_pkg::out_item_t record_event(dtcffr_pkg::in_item_t w);
    dtcffr_pkg::out_item_t r;
    r = '0;
    case (w.action)
      dtcffr_pkg::ACT_CHECK: begin
        for (int i = 0; i < NUM_SENSORS; i++) begin
          if (w.critical_mask[i]) begin
            if (!last_critical[i]) begin
              if (occurrences[i] != COUNT_MAX) occurrences[i]++;
              if (!frame.valid) begin
                frame.valid       = 1'b1;
                frame.trigger     = dtcffr_pkg::TRIG_W'(i);
                frame.speed       = w.speed;
                frame.rpm         = w.rpm;
                frame.temperature = w.temperature;
              end
            end
            code_st[i] = dtcffr_pkg::ST_ACTIVE;
          end else if (code_st[i] == dtcffr_pkg::ST_ACTIVE) begin
            code_st[i] = dtcffr_pkg::ST_HISTORY;
          end
        end
        last_critical = w.critical_mask;
      end
      dtcffr_pkg::ACT_CLEAR_ALL: clear_records();
      dtcffr_pkg::ACT_CLEAR_SENSOR: begin
        // Previous flags stay; an out-of-range index does nothing
        if (w.sensor_select < NUM_SENSORS) begin
          occurrences[w.sensor_select] = '0;
          code_st[w.sensor_select]     = dtcffr_pkg::ST_NONE;
          if (frame.valid && frame.trigger == w.sensor_select) frame = '0;
        end
      end
      default: ;
    endcase
    for (int i = 0; i < NUM_SENSORS; i++) begin
      r.status_vector[dtcffr_pkg::STATUS_W*i +: dtcffr_pkg::STATUS_W] = code_st[i];
      r.count_vector[COUNT_BITS*i +: COUNT_BITS] = occurrences[i];
    end
    r.frozen_valid       = frame.valid;
    r.frozen_trigger     = frame.trigger;
    r.frozen_speed       = frame.speed;
    r.frozen_rpm         = frame.rpm;
    r.frozen_temperature = frame.temperature;
    return r;
  endfunction

  // Mostly zero, sometimes a few cycles, rarely a long pause
  function automatic int unsigned pick_pause();
    int unsigned roll;
    roll = $urandom_range(0, 99);
    if (steady || roll < 55) return 0;
    if (roll < 92) return $urandom_range(1, 3);
    return $urandom_range(8, 30);
  endfunction

  function automatic dtcffr_pkg::in_item_t make_word(logic [1:0] act,
                                                     logic [dtcffr_pkg::MASK_W-1:0] mask,
                                                     logic [7:0] spd, logic [13:0] rev,
                                                     logic signed [7:0] temp,
                                                     logic [dtcffr_pkg::SEL_W-1:0] sel);
    dtcffr_pkg::in_item_t w;
    w.action        = act;
    w.critical_mask = mask;
    w.speed         = spd;
    w.rpm           = rev;
    w.temperature   = temp;
    w.sensor_select = sel;
    return w;
  endfunction

  function automatic dtcffr_pkg::in_item_t random_word(logic [1:0] act);
    return make_word(act, dtcffr_pkg::MASK_W'($urandom), 8'($urandom), 14'($urandom),
                     8'($urandom), dtcffr_pkg::SEL_W'($urandom));
  endfunction

  // Offer one word after a random gap; valid stays high for a back-to-back word
  task automatic send_word(dtcffr_pkg::in_item_t w);
    int unsigned gap;
    gap = pick_pause();
    @(negedge clk_i);
    if (gap != 0) begin
      in_if.valid <= 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    in_if.valid   <= 1'b1;
    in_if.payload <= w;
    do @(posedge clk_i); while (!in_if.ready);
    expected_reports.push_back(record_event(w));
    words_sent++;
  endtask

  // Hold the sender until every outstanding report has come back
  task automatic drain_reports();
    @(negedge clk_i);
    in_if.valid <= 1'b0;
    while (expected_reports.size() != 0) @(posedge clk_i);
  endtask

  task automatic test_reset_state();
    send_word(make_word(ACT_UNUSED, '1, '1, '1, '1, '1));
    send_word(make_word(dtcffr_pkg::ACT_CLEAR_ALL, '0, '0, '0, '0, '0));
  endtask

  task automatic test_directed();
    // two sensors rise together: lowest index captures; speed and rpm at maxima, temperature at minimum
    send_word(make_word(dtcffr_pkg::ACT_CHECK, 3'b110, 8'd255, 14'd16383, -8'sd128, '0));
    // sensor 0 rises later; frame already held
    send_word(make_word(dtcffr_pkg::ACT_CHECK, 3'b111, 8'd0, 14'd0, 8'sd127, '1));
    send_word(make_word(dtcffr_pkg::ACT_CHECK, 3'b000, 8'd5, 14'd5, 8'sd5, '0));
    send_word(make_word(dtcffr_pkg::ACT_CLEAR_SENSOR, 3'b111, 8'd1, 14'd1, 8'sd1,
                        SEL_OUT_OF_RANGE));
    // clear a sensor that did not trigger, then the one that did
    send_word(make_word(dtcffr_pkg::ACT_CLEAR_SENSOR, '0, '0, '0, '0, 2'd0));
    send_word(make_word(dtcffr_pkg::ACT_CLEAR_SENSOR, '0, '0, '0, '0, 2'd1));
    send_word(make_word(dtcffr_pkg::ACT_CHECK, 3'b100, 8'd17, 14'd8191, -8'sd1, '0));
    // clear while still critical: no new edge next check, but active again
    send_word(make_word(dtcffr_pkg::ACT_CLEAR_SENSOR, 3'b100, '0, '0, '0, 2'd2));
    send_word(make_word(dtcffr_pkg::ACT_CHECK, 3'b100, 8'd99, 14'd1234, 8'sd40, '0));
    send_word(make_word(dtcffr_pkg::ACT_CHECK, 3'b001, 8'd128, 14'd4096, -8'sd64, '0));
    send_word(make_word(ACT_UNUSED, 3'b010, 8'd3, 14'd3, 8'sd3, 2'd1));
    send_word(make_word(dtcffr_pkg::ACT_CLEAR_ALL, '1, '1, '1, '1, '1));
    // previous flags were cleared, so this counts a fresh edge
    send_word(make_word(dtcffr_pkg::ACT_CHECK, 3'b001, 8'd42, 14'd42, 8'sd42, '0));
    send_word(make_word(dtcffr_pkg::ACT_CHECK, 3'b011, 8'd43, 14'd43, 8'sd43, '0));
    send_word(make_word(dtcffr_pkg::ACT_CLEAR_ALL, '0, '0, '0, '0, '0));
  endtask

  // Toggle all sensors until every count pins at its maximum
  task automatic test_count_saturation();
    dtcffr_pkg::in_item_t w;
    drain_reports();
    send_word(make_word(dtcffr_pkg::ACT_CLEAR_ALL, '0, '0, '0, '0, '0));
    for (int n = 0; n < SAT_PAIRS; n++) begin
      steady = (n % 64) < 16;
      w = random_word(dtcffr_pkg::ACT_CHECK);
      w.critical_mask = '1;
      send_word(w);
      w = random_word(dtcffr_pkg::ACT_CHECK);
      w.critical_mask = '0;
      send_word(w);
    end
    steady = 1'b0;
    send_word(make_word(dtcffr_pkg::ACT_CLEAR_SENSOR, '0, '0, '0, '0, 2'd1));
    send_word(make_word(dtcffr_pkg::ACT_CHECK, 3'b010, 8'd7, 14'd7, 8'sd7, '0));
  endtask

  // Mostly checks with random masks; clears and unused codes mixed in
  task automatic test_random_traffic();
    int unsigned roll;
    for (int n = 0; n < RANDOM_WORDS; n++) begin
      if (n % 50 == 0) steady = ($urandom_range(0, 3) == 0);
      if (n == RANDOM_WORDS / 2) drain_reports();
      roll = $urandom_range(0, 99);
      if (roll < 75)      send_word(random_word(dtcffr_pkg::ACT_CHECK));
      else if (roll < 88) send_word(random_word(dtcffr_pkg::ACT_CLEAR_SENSOR));
      else if (roll < 94) send_word(random_word(dtcffr_pkg::ACT_CLEAR_ALL));
      else                send_word(random_word(ACT_UNUSED));
    end
    steady = 1'b0;
  endtask

  // Drive result ready with random stalls
  initial begin
    int unsigned stall_left;
    stall_left = 0;
    out_if.ready = 1'b0;
    forever begin
      @(negedge clk_i);
      if (steady) begin
        out_if.ready <= 1'b1;
      end else if (stall_left != 0) begin
        out_if.ready <= 1'b0;
        stall_left--;
      end else begin
        out_if.ready <= 1'b1;
        stall_left = pick_pause();
      end
    end
  end

  function automatic void compare_field(string name, logic [31:0] want, logic [31:0] seen);
    if (want !== seen) begin
      $display("%0t: %s mismatch: expected %0h, got %0h", $time, name, want, seen);
      errors++;
    end
  endfunction

  // Compare each accepted report with the oldest prediction
  always @(posedge clk_i) begin
    dtcffr_pkg::out_item_t got;
    dtcffr_pkg::out_item_t want;
    if (rst_ni && out_if.valid && out_if.ready) begin
      got = out_if.payload;
      reports_seen++;
      if (expected_reports.size() == 0) begin
        $display("%0t: unexpected report, expected none, got %0h", $time, got);
        errors++;
      end else begin
        want = expected_reports.pop_front();
        compare_field("status_vector", want.status_vector, got.status_vector);
        compare_field("count_vector", want.count_vector, got.count_vector);
        compare_field("frozen_valid", want.frozen_valid, got.frozen_valid);
        compare_field("frozen_trigger", want.frozen_trigger, got.frozen_trigger);
        compare_field("frozen_speed", want.frozen_speed, got.frozen_speed);
        compare_field("frozen_rpm", want.frozen_rpm, got.frozen_rpm);
        compare_field("frozen_temperature", want.frozen_temperature,
                      got.frozen_temperature);
      end
    end
  end

  initial begin
    $timeformat(-9, 0, " ns", 0);
    in_if.valid = 1'b0;
    in_if.payload = '0;
    clear_records();
    repeat (6) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    test_reset_state();
    test_directed();
    test_count_saturation();
    test_random_traffic();

    drain_reports();
    repeat (10) @(posedge clk_i);
    $display("Sent %0d words (directed, count saturation, random traffic);", words_sent);
    $display("checked %0d reports, %0d left outstanding.", reports_seen,
             expected_reports.size());
    if (errors == 0 && expected_reports.size() == 0) begin
      $display("** dtc_freeze_frame_recorder_unit: PASSED **");
    end else begin
      $display("** dtc_freeze_frame_recorder_unit: FAILED **");
    end
    $finish;
  end

  // Watchdog
  initial begin
    #2000000;
    $display("Timeout with %0d reports outstanding", expected_reports.size());
    $display("** dtc_freeze_frame_recorder_unit: FAILED **");
    $finish;
  end

endmodule
